// ===== sv/msp_pkg.sv =====
// ---------------------------------------------------------------------------
// Motor speed PID drive package
// Shared constants, register indexes, payload and link types.
// ---------------------------------------------------------------------------
package msp_pkg;

    localparam int GAIN_FRAC_BITS = 20;
    localparam int SPEED_BITS     = 12;
    localparam int GAIN_W         = 24;
    localparam int DUTY_W         = 12;
    localparam int SUM_W          = 32;
    localparam int ERR_W          = SPEED_BITS + 1;
    localparam int DIFF_W         = SPEED_BITS + 2;
    localparam int PK_W           = GAIN_W + 1 + ERR_W;
    localparam int PI_W           = GAIN_W + 1 + SUM_W;
    localparam int PD_W           = GAIN_W + 1 + DIFF_W;
    localparam int ACC_W          = PI_W + 2;
    localparam int Q_W            = ACC_W - GAIN_FRAC_BITS;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DUTY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DRIVE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;

    typedef enum logic [1:0] {
        MODE_STOP,
        MODE_HOLD,
        MODE_START,
        MODE_PID
    } mode_t;

    typedef struct packed {
        logic                  run;
        logic                  start_phase;
        logic [SPEED_BITS-1:0] target_speed;
        logic [SPEED_BITS-1:0] measured_speed;
    } msp_in_t;

    typedef struct packed {
        logic [DUTY_W-1:0] compare_value;
        logic              motor_on;
    } msp_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] kp_gain;
        logic [GAIN_W-1:0] ki_gain;
        logic [GAIN_W-1:0] kd_gain;
        logic [DUTY_W-1:0] start_duty;
        logic [DUTY_W-1:0] min_drive;
        logic [DUTY_W-1:0] drive_limit;
    } msp_cfg_t;

    typedef struct packed {
        mode_t                   mode;
        logic                    run;
        logic signed [PK_W-1:0]  prod_p;
        logic signed [PI_W-1:0]  prod_i;
        logic signed [PD_W-1:0]  prod_d;
    } msp_link_t;

endpackage

// ===== sv/msp_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Configuration registers
// Holds the PID gains, start duty, minimum drive and drive limit.
// ---------------------------------------------------------------------------
module msp_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data,
    output msp_pkg::msp_cfg_t               cfg
);
    import msp_pkg::*;

    msp_cfg_t cfg_reg;
    msp_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_KP_GAIN:     cfg_next.kp_gain     = cfg_data[GAIN_W-1:0];
                REG_KI_GAIN:     cfg_next.ki_gain     = cfg_data[GAIN_W-1:0];
                REG_KD_GAIN:     cfg_next.kd_gain     = cfg_data[GAIN_W-1:0];
                REG_START_DUTY:  cfg_next.start_duty  = cfg_data[DUTY_W-1:0];
                REG_MIN_DRIVE:   cfg_next.min_drive   = cfg_data[DUTY_W-1:0];
                REG_DRIVE_LIMIT: cfg_next.drive_limit = cfg_data[DUTY_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp_gain     <= GAIN_W'(36700);
            cfg_reg.ki_gain     <= GAIN_W'(692);
            cfg_reg.kd_gain     <= GAIN_W'(472);
            cfg_reg.start_duty  <= DUTY_W'(45);
            cfg_reg.min_drive   <= DUTY_W'(22);
            cfg_reg.drive_limit <= DUTY_W'(2500);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/msp_err_stage.sv =====
// ---------------------------------------------------------------------------
// Error stage
// Registers the request, updates the error sum and previous error on PID
// ticks, and forms the three gain products.
// ---------------------------------------------------------------------------
module msp_err_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msp_pkg::msp_cfg_t    cfg,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  msp_pkg::msp_in_t     in_data,
    output logic                 link_valid,
    input  logic                 link_ready,
    output msp_pkg::msp_link_t   link
);
    import msp_pkg::*;

    logic                     req_valid_reg;
    msp_in_t                  req_reg;
    logic                     link_valid_reg;
    msp_link_t                link_reg;
    msp_link_t                link_next;
    logic signed [SUM_W-1:0]  error_sum_reg;
    logic signed [SUM_W-1:0]  error_sum_next;
    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W:0]    sum_wide;
    logic                     take_req;
    logic                     move_link;
    logic                     pid_step;

    assign move_link  = !link_valid_reg || link_ready;
    assign take_req   = !req_valid_reg || move_link;
    assign in_stall   = !take_req;
    assign link_valid = link_valid_reg;
    assign link       = link_reg;
    assign pid_step   = move_link && req_valid_reg && (link_next.mode == MODE_PID);

    always_comb
    begin
        err = $signed({1'b0, req_reg.target_speed}) - $signed({1'b0, req_reg.measured_speed});
        sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
        begin
            error_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
        end
        else
        begin
            error_sum_next = sum_wide[SUM_W-1:0];
        end
        diff = DIFF_W'(err) - DIFF_W'(prev_err_reg);

        if (!req_reg.run)
        begin
            link_next.mode = MODE_STOP;
        end
        else if (req_reg.target_speed == '0)
        begin
            link_next.mode = MODE_HOLD;
        end
        else if (req_reg.start_phase)
        begin
            link_next.mode = MODE_START;
        end
        else
        begin
            link_next.mode = MODE_PID;
        end
        link_next.run    = req_reg.run;
        link_next.prod_p = PK_W'($signed({1'b0, cfg.kp_gain})) * PK_W'(err);
        link_next.prod_i = PI_W'($signed({1'b0, cfg.ki_gain})) * PI_W'(error_sum_next);
        link_next.prod_d = PD_W'($signed({1'b0, cfg.kd_gain})) * PD_W'(diff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg  <= 1'b0;
            link_valid_reg <= 1'b0;
            error_sum_reg  <= '0;
            prev_err_reg   <= '0;
        end
        else
        begin
            if (take_req)
            begin
                req_valid_reg <= in_valid;
            end
            if (move_link)
            begin
                link_valid_reg <= req_valid_reg;
            end
            if (pid_step)
            begin
                error_sum_reg <= error_sum_next;
                prev_err_reg  <= err;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_req)
        begin
            req_reg <= in_data;
        end
        if (move_link)
        begin
            link_reg <= link_next;
        end
    end

endmodule

// ===== sv/msp_drive_stage.sv =====
// ---------------------------------------------------------------------------
// Drive stage
// Sums the gain products, scales them and applies the floor and limit;
// picks the compare value by mode and holds the result for the receiver.
// ---------------------------------------------------------------------------
module msp_drive_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  msp_pkg::msp_cfg_t    cfg,
    input  logic                 link_valid,
    output logic                 link_ready,
    input  msp_pkg::msp_link_t   link,
    output logic                 out_valid,
    input  logic                 out_stall,
    output msp_pkg::msp_out_t    out_data
);
    import msp_pkg::*;

    logic                    out_valid_reg;
    msp_out_t                out_reg;
    msp_out_t                out_next;
    logic [DUTY_W-1:0]       drive_reg;
    logic [DUTY_W-1:0]       drive_next;
    logic [DUTY_W-1:0]       applied_reg;
    logic [DUTY_W-1:0]       applied_next;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_biased;
    logic signed [Q_W-1:0]   quot;
    logic signed [Q_W-1:0]   floored;
    logic signed [Q_W-1:0]   min_ext;
    logic signed [Q_W-1:0]   limit_ext;
    logic                    move_out;
    logic                    step;

    assign move_out   = !out_valid_reg || !out_stall;
    assign link_ready = move_out;
    assign step       = move_out && link_valid;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_comb
    begin
        acc = ACC_W'(link.prod_p) + ACC_W'(link.prod_i) + ACC_W'(link.prod_d);
        // Rounding toward zero: bias negative sums before the arithmetic shift.
        if (acc[ACC_W-1])
        begin
            acc_biased = acc + $signed({{(ACC_W-GAIN_FRAC_BITS){1'b0}},
                                        {GAIN_FRAC_BITS{1'b1}}});
        end
        else
        begin
            acc_biased = acc;
        end
        quot      = acc_biased[ACC_W-1:GAIN_FRAC_BITS];
        min_ext   = $signed({{(Q_W-DUTY_W){1'b0}}, cfg.min_drive});
        limit_ext = $signed({{(Q_W-DUTY_W){1'b0}}, cfg.drive_limit});
        floored   = (quot < min_ext) ? min_ext : quot;

        drive_next   = drive_reg;
        applied_next = applied_reg;
        unique case (link.mode)
            MODE_STOP:
            begin
                applied_next = '0;
            end
            MODE_HOLD:
            begin
                applied_next = applied_reg;
            end
            MODE_START:
            begin
                applied_next = cfg.start_duty;
            end
            MODE_PID:
            begin
                if ((floored > $signed(Q_W'(0))) && (floored < limit_ext))
                begin
                    drive_next = floored[DUTY_W-1:0];
                end
                applied_next = drive_next;
            end
            default:
            begin
                applied_next = applied_reg;
            end
        endcase

        out_next.compare_value = applied_next;
        out_next.motor_on      = link.run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            drive_reg     <= '0;
            applied_reg   <= '0;
        end
        else
        begin
            if (move_out)
            begin
                out_valid_reg <= link_valid;
            end
            if (step)
            begin
                drive_reg   <= drive_next;
                applied_reg <= applied_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ===== sv/motor_speed_pid_drive.sv =====
// ---------------------------------------------------------------------------
// Motor speed PID drive
// Positional PID speed loop giving a PWM compare value and motor enable.
// ---------------------------------------------------------------------------
// Each input request carries the run flag, the start-phase flag, the target
// speed and the measured speed; each produces exactly one result with the
// compare value now applied and the motor enable level. Both channels use
// valid and stall; a request moves when valid is high and stall is low.
// The configuration channel (valid, ready, index, data) is always ready and
// should only be written while no request is in flight.
// From acceptance a request passes an input register, an error stage that
// updates the error sum and forms the three gain products, and a drive
// stage that scales, limits and registers the result. One request is
// accepted every cycle while the receiver does not stall; the rate is set
// by the error sum update. When the receiver stalls, the pipeline keeps
// filling until every stage is occupied, then stalls the sender. Reset
// clears the PID state, the stored drive and the applied compare value,
// and loads the default gains.
// ---------------------------------------------------------------------------
module motor_speed_pid_drive (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  msp_pkg::msp_in_t                in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output msp_pkg::msp_out_t               out_data
);
    import msp_pkg::*;

    msp_cfg_t  cfg;
    msp_link_t link;
    logic      link_valid;
    logic      link_ready;

    msp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    msp_err_stage u_err (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link       (link)
    );

    msp_drive_stage u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .link_valid (link_valid),
        .link_ready (link_ready),
        .link       (link),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// Motor speed PID drive testbench
// Drives control ticks into the speed loop and checks every compare value and
// motor enable against a cycle-free predictor of the loop kept in this file.
// Directed ticks cover stop, hold, start phase and PID ticks; register
// settings run through their extremes; random traffic runs under bursty
// requests and a stalling receiver. One long hold-off fills the pipeline, and
// a final stretch ramps the error sum up and back down.
// ---------------------------------------------------------------------------
module tb_top;
    import msp_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 4000000;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          RAND_PHASES  = 8;
    localparam int          PHASE_ITEMS  = 160;
    localparam int          RAMP_ITEMS   = 32;
    localparam longint      SUM_MAX      = 64'sd2147483647;
    localparam longint      SUM_MIN      = -SUM_MAX - 1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    msp_in_t               in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    msp_out_t              out_data;

    msp_cfg_t                   loop_cfg;
    logic signed [SUM_W-1:0]    err_sum_q   = '0;
    logic signed [ERR_W-1:0]    prev_err_q  = '0;
    logic [DUTY_W-1:0]          drive_q     = '0;
    logic [DUTY_W-1:0]          compare_q   = '0;
    msp_out_t                   pending_compares[$];

    int          fault_count = 0;
    int          result_count = 0;
    int unsigned cycle_count = 0;
    bit          stall_on = 1'b0;
    bit          gaps_on = 1'b0;
    logic        hold_req = 1'b0;
    int          hold_cnt = 0;
    bit          pace_stall = 1'b0;
    int          pace_left = 0;

    motor_speed_pid_drive i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        loop_cfg = '{kp_gain: 24'd36700, ki_gain: 24'd692, kd_gain: 24'd472,
                     start_duty: 12'd45, min_drive: 12'd22, drive_limit: 12'd2500};
    end

    function automatic void load_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_KP_GAIN:     loop_cfg.kp_gain     = value;
            REG_KI_GAIN:     loop_cfg.ki_gain     = value;
            REG_KD_GAIN:     loop_cfg.kd_gain     = value;
            REG_START_DUTY:  loop_cfg.start_duty  = value[DUTY_W-1:0];
            REG_MIN_DRIVE:   loop_cfg.min_drive   = value[DUTY_W-1:0];
            REG_DRIVE_LIMIT: loop_cfg.drive_limit = value[DUTY_W-1:0];
            default: ;
        endcase
    endfunction

    // One control tick of the speed loop; updates the predicted state.
    function automatic msp_out_t step_speed_loop(input msp_in_t req);
        msp_out_t res;
        longint   err;
        longint   sum;
        longint   diff;
        longint   acc;
        longint   drive;
        if (!req.run)
            compare_q = '0;
        else if (req.target_speed != '0)
        begin
            if (req.start_phase)
                compare_q = loop_cfg.start_duty;
            else
            begin
                err = longint'(req.target_speed) - longint'(req.measured_speed);
                sum = longint'(err_sum_q) + err;
                if (sum > SUM_MAX)
                    sum = SUM_MAX;
                if (sum < SUM_MIN)
                    sum = SUM_MIN;
                err_sum_q  = sum[SUM_W-1:0];
                diff       = err - longint'(prev_err_q);
                prev_err_q = err[ERR_W-1:0];
                acc = longint'(loop_cfg.kp_gain) * err
                    + longint'(loop_cfg.ki_gain) * sum
                    + longint'(loop_cfg.kd_gain) * diff;
                drive = acc / (longint'(1) << GAIN_FRAC_BITS);
                if (drive < longint'(loop_cfg.min_drive))
                    drive = longint'(loop_cfg.min_drive);
                if (drive > 0 && drive < longint'(loop_cfg.drive_limit))
                    drive_q = drive[DUTY_W-1:0];
                compare_q = drive_q;
            end
        end
        res.compare_value = compare_q;
        res.motor_on      = req.run;
        return res;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        load_register(idx, value);
    endtask

    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [DUTY_W-1:0] v);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom);
        w[DUTY_W-1:0] = v;
        return w;
    endfunction

    task automatic set_config(input msp_cfg_t c);
        write_reg(REG_KP_GAIN, c.kp_gain);
        write_reg(REG_KI_GAIN, c.ki_gain);
        write_reg(REG_KD_GAIN, c.kd_gain);
        write_reg(REG_START_DUTY, with_junk(c.start_duty));
        write_reg(REG_MIN_DRIVE, with_junk(c.min_drive));
        write_reg(REG_DRIVE_LIMIT, with_junk(c.drive_limit));
        cfg_valid <= 1'b0;
    endtask

    task automatic send_request(input msp_in_t req);
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_compares.push_back(step_speed_loop(req));
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_compares.size() != 0);
    endtask

    function automatic msp_in_t tick(input logic run, input logic start,
                                     input int target, input int measured);
        msp_in_t req;
        req.run            = run;
        req.start_phase    = start;
        req.target_speed   = target[SPEED_BITS-1:0];
        req.measured_speed = measured[SPEED_BITS-1:0];
        return req;
    endfunction

    function automatic msp_in_t random_request();
        msp_in_t req;
        int      pick;
        int      near;
        req  = tick(1'b1, 1'b0, $urandom_range(1, 4095), $urandom_range(0, 4095));
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            req.run          = 1'b0;
            req.start_phase  = 1'($urandom_range(0, 1));
            req.target_speed = SPEED_BITS'($urandom_range(0, 4095));
        end
        else if (pick < 16)
        begin
            req.start_phase  = 1'($urandom_range(0, 1));
            req.target_speed = '0;
        end
        else if (pick < 26)
            req.start_phase = 1'b1;
        else if (pick < 70)
        begin
            near = int'(req.target_speed) + int'($urandom_range(0, 64)) - 32;
            if (near < 0)
                near = 0;
            if (near > 4095)
                near = 4095;
            req.measured_speed = near[SPEED_BITS-1:0];
        end
        return req;
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain(input int span);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return GAIN_W'($urandom_range(0, span));
        endcase
    endfunction

    function automatic msp_cfg_t random_config();
        msp_cfg_t c;
        c.kp_gain    = pick_gain(1 << 20);
        c.ki_gain    = pick_gain(1 << 12);
        c.kd_gain    = pick_gain(1 << 20);
        c.start_duty = DUTY_W'($urandom_range(0, 4095));
        c.min_drive  = DUTY_W'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                           : $urandom_range(0, 200));
        case ($urandom_range(0, 5))
            0:       c.drive_limit = '1;
            1:       c.drive_limit = 12'd1;
            default: c.drive_limit = DUTY_W'($urandom_range(1, 4095));
        endcase
        return c;
    endfunction

    task automatic send_random(input int count);
        int burst;
        int gap;
        burst = 0;
        for (int k = 0; k < count; k++)
        begin
            if (burst == 0)
            begin
                gap = gaps_on ? $urandom_range(0, 6) : 0;
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst = $urandom_range(1, 24);
            end
            send_request(random_request());
            burst--;
        end
        in_valid <= 1'b0;
    endtask

    task automatic check_result(input msp_out_t got);
        msp_out_t want;
        if (pending_compares.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                $display("result %0d with none expected: compare %0d motor %0d",
                         result_count, got.compare_value, got.motor_on);
        end
        else
        begin
            want = pending_compares.pop_front();
            if (got.compare_value !== want.compare_value || got.motor_on !== want.motor_on)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result %0d: expected compare %0d motor %0d, got compare %0d motor %0d",
                             result_count, want.compare_value, want.motor_on,
                             got.compare_value, got.motor_on);
            end
        end
        result_count++;
    endtask

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            check_result(out_data);
        if (hold_req || hold_cnt != 0)
            out_stall <= 1'b1;
        else if (!stall_on)
            out_stall <= 1'b0;
        else
        begin
            if (pace_left == 0)
            begin
                pace_stall = !pace_stall;
                pace_left  = pace_stall ? $urandom_range(1, 5) : $urandom_range(1, 12);
            end
            pace_left--;
            out_stall <= pace_stall;
        end
    end

    always @(posedge clk)
    begin
        if (hold_req)
            hold_cnt <= HOLD_CYCLES;
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic test_modes();
        send_request(tick(1'b0, 1'b0, 0, 0));
        send_request(tick(1'b1, 1'b0, 0, 4095));
        send_request(tick(1'b1, 1'b1, 4095, 0));
        send_request(tick(1'b1, 1'b1, 0, 4095));
        send_request(tick(1'b0, 1'b1, 4095, 4095));
        send_request(tick(1'b1, 1'b0, 4095, 0));
        send_request(tick(1'b1, 1'b0, 1, 4095));
        send_request(tick(1'b1, 1'b0, 4095, 4095));
        send_request(tick(1'b1, 1'b0, 2730, 1365));
        send_request(tick(1'b1, 1'b0, 1365, 2730));
        send_request(tick(1'b1, 1'b1, 1, 2048));
        send_request(tick(1'b0, 1'b0, 2048, 1));
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_register_extremes();
        msp_cfg_t settings[4];
        settings[0] = '{kp_gain: '0, ki_gain: '0, kd_gain: '0,
                        start_duty: '0, min_drive: '0, drive_limit: '0};
        settings[1] = '{kp_gain: '1, ki_gain: '1, kd_gain: '1,
                        start_duty: '1, min_drive: '1, drive_limit: '1};
        settings[2] = '{kp_gain: '0, ki_gain: '0, kd_gain: '0,
                        start_duty: 12'd2048, min_drive: 12'd4094, drive_limit: '1};
        settings[3] = '{kp_gain: 24'd1 << GAIN_FRAC_BITS, ki_gain: '0, kd_gain: '0,
                        start_duty: 12'd1, min_drive: '0, drive_limit: 12'd1};
        foreach (settings[s])
        begin
            set_config(settings[s]);
            send_request(tick(1'b1, 1'b0, 4095, 0));
            send_request(tick(1'b1, 1'b0, 1, 4095));
            send_request(tick(1'b1, 1'b1, 300, 17));
            in_valid <= 1'b0;
            wait_drained();
        end
        // Writes to the unused indexes must leave every register as it was.
        write_reg(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        send_request(tick(1'b1, 1'b0, 1000, 900));
        in_valid <= 1'b0;
        wait_drained();
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            stall_on = (p != 0);
            gaps_on  = (p != 0);
            set_config(random_config());
            send_random(PHASE_ITEMS);
            wait_drained();
        end
    endtask

    task automatic test_backpressure();
        stall_on = 1'b0;
        gaps_on  = 1'b0;
        set_config(random_config());
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        send_random(48);
        wait_drained();
    endtask

    task automatic test_integral_ramp();
        msp_cfg_t c;
        stall_on = 1'b0;
        gaps_on  = 1'b0;
        c = '{kp_gain: '0, ki_gain: 24'd1 << 12, kd_gain: '0,
              start_duty: 12'd45, min_drive: '0, drive_limit: '1};
        set_config(c);
        // With only the integral gain the compare value follows the error sum.
        repeat (RAMP_ITEMS) send_request(tick(1'b1, 1'b0, 4095, 0));
        repeat (RAMP_ITEMS) send_request(tick(1'b1, 1'b0, 1, 4095));
        in_valid <= 1'b0;
        wait_drained();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_modes();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        test_integral_ramp();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0 && pending_compares.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
